/* rtl/c8ie_pkg.sv */
`timescale 1ns / 1ps
// shared constants and types of the interpreter execute block
// no dependencies

package c8ie_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SADDR_W     = $clog2(STACK_DEPTH);

  localparam int NUM_VREGS = 16;
  localparam int VREG_W    = $clog2(NUM_VREGS);

  localparam int PC_W  = 12;
  localparam int IDX_W = 16;
  localparam int DAT_W = 8;

  localparam logic [PC_W-1:0] PC_RESET = 12'h200;
  localparam logic [VREG_W-1:0] VF_REG = 4'hF;

  // top nibble of the instruction
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [11:0] SYS_CLS = 12'h0E0;
  localparam logic [11:0] SYS_RET = 12'h0EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_SHR = 4'h6;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] MISC_GET_DT = 8'h07;
  localparam logic [7:0] MISC_SET_DT = 8'h15;
  localparam logic [7:0] MISC_ADD_I  = 8'h1E;

  typedef enum logic [1:0] {
    ST_EXEC  = 2'd0,
    ST_NOP   = 2'd1,
    ST_HALT  = 2'd2,
    ST_FAULT = 2'd3
  } status_e;

  localparam int OUT_BITS = PC_W + IDX_W + 1 + VREG_W + DAT_W + 2;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

/* rtl/chip8_instruction_execute_top.sv */
`timescale 1ns / 1ps
// Executes one 16-bit instruction per input beat and returns one result beat with the new
// program counter, index, register write and status. An accepted beat is registered, its
// registers are read from small rams at the same edge, and it executes from the instruction
// register into the result register once that register is free; one instruction per cycle is
// sustained while m_axis_tready does not stall the result. After an illegal opcode or a stack
// fault the core stays halted until reset.
// depends on c8ie_pkg and c8ie_ram

module chip8_instruction_execute_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // instruction[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [c8ie_pkg::OUT_TDATA_W-1:0] m_axis_tdata
  // m_axis_tdata: next_pc[11:0], index_value[27:12], dest_written[28], dest_reg[32:29],
  // dest_value[40:33], status[42:41], zero fill
);

  import c8ie_pkg::*;

  // handshake and stage control
  logic s_fire, ex_fire;
  logic in_vld_q, in_vld_d;
  logic [15:0] ins_q;
  logic out_vld_q, out_vld_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // architectural state
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [IDX_W-1:0] idx_q, idx_d, idx_nx;
  logic [SP_W-1:0]  sp_q, sp_d, sp_nx;
  logic [DAT_W-1:0] dly_q, dly_d, dly_nx;
  logic [DAT_W-1:0] vf_q, vf_d;
  logic [NUM_VREGS-1:0] vld_q, vld_d;
  logic halted_q, halted_d;

  // register file read path
  logic [VREG_W-1:0] rx_addr, ry_addr;
  logic [DAT_W-1:0]  vx_rd, vy_rd;
  logic vx_hit_q, vy_hit_q, vx_live_q, vy_live_q;
  logic [DAT_W-1:0] vx_fwd_q, vy_fwd_q;
  logic vx_hit, vy_hit;
  logic [DAT_W-1:0] vx, vy;

  // register file write path
  logic ram_we, vf_we;
  logic [DAT_W-1:0] vf_wd;

  // return stack
  logic [SP_W-1:0]    sp_rd;
  logic [SADDR_W-1:0] st_raddr;
  logic [PC_W-1:0]    st_rd, st_top, st_fwd_q;
  logic st_hit, st_hit_q, push;

  // decode
  logic [3:0] op, n;
  logic [VREG_W-1:0] x, y;
  logic [7:0] nn;
  logic [11:0] nnn;
  status_e st, st_out;
  logic [PC_W-1:0] next_pc, pc_out;
  logic wr, shr, fault, commit;
  logic [DAT_W-1:0] wval;

  assign op  = ins_q[15:12];
  assign x   = ins_q[11:8];
  assign y   = ins_q[7:4];
  assign n   = ins_q[3:0];
  assign nn  = ins_q[7:0];
  assign nnn = ins_q[11:0];

  assign ex_fire       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || ex_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (ex_fire) begin
      in_vld_d = 1'b0;
    end
  end

  // operand select with same-edge forwarding and reset-zero for unwritten entries
  assign vx = (x == VF_REG) ? vf_q :
              vx_hit_q ? vx_fwd_q : (vx_live_q ? vx_rd : '0);
  assign vy = (y == VF_REG) ? vf_q :
              vy_hit_q ? vy_fwd_q : (vy_live_q ? vy_rd : '0);
  assign st_top = st_hit_q ? st_fwd_q : st_rd;

  always_comb begin
    st     = ST_EXEC;
    next_pc = pc_q + PC_W'(2);
    wr     = 1'b0;
    shr    = 1'b0;
    wval   = '0;
    idx_nx = idx_q;
    dly_nx = dly_q;
    sp_nx  = sp_q;
    push   = 1'b0;
    unique case (op)
      OP_SYS: begin
        if (nnn == SYS_CLS) begin
          st = ST_NOP;
        end else if (nnn == SYS_RET) begin
          if (sp_q == '0) begin
            st = ST_FAULT;
          end else begin
            sp_nx   = sp_q - SP_W'(1);
            next_pc = st_top + PC_W'(2);
          end
        end else begin
          st = ST_HALT;
        end
      end
      OP_JP: next_pc = nnn;
      OP_CALL: begin
        if (sp_q >= SP_W'(STACK_DEPTH)) begin
          st = ST_FAULT;
        end else begin
          push    = 1'b1;
          sp_nx   = sp_q + SP_W'(1);
          next_pc = nnn;
        end
      end
      OP_SE: begin
        if (vx == nn) begin
          next_pc = pc_q + PC_W'(4);
        end
      end
      OP_LD: begin
        wr   = 1'b1;
        wval = nn;
      end
      OP_ADD: begin
        wr   = 1'b1;
        wval = vx + nn;
      end
      OP_ALU: begin
        unique case (n)
          ALU_MOV: begin
            wr   = 1'b1;
            wval = vy;
          end
          ALU_AND: begin
            wr   = 1'b1;
            wval = vx & vy;
          end
          ALU_SHR: begin
            wr   = 1'b1;
            shr  = 1'b1;
            // flag lands in vf after the shift, so it wins when x is vf
            wval = (x == VF_REG) ? {{(DAT_W-1){1'b0}}, vx[0]} : (vx >> 1);
          end
          default: st = ST_HALT;
        endcase
      end
      OP_LDI: idx_nx = {{(IDX_W-12){1'b0}}, nnn};
      OP_DRW: st = ST_NOP;
      OP_KEY: begin
        if (nn == KEY_SKP || nn == KEY_SKNP) begin
          st = ST_NOP;
        end else begin
          st = ST_HALT;
        end
      end
      OP_MISC: begin
        unique case (nn)
          MISC_GET_DT: begin
            wr   = 1'b1;
            wval = dly_q;
          end
          MISC_SET_DT: dly_nx = vx;
          MISC_ADD_I:  idx_nx = idx_q + {{(IDX_W-DAT_W){1'b0}}, vx};
          default:     st = ST_HALT;
        endcase
      end
      default: st = ST_HALT;
    endcase
  end

  assign fault  = (st == ST_HALT) || (st == ST_FAULT);
  assign commit = ex_fire && !halted_q && !fault;

  assign st_out = halted_q ? ST_HALT : st;
  assign pc_out = (halted_q || fault) ? pc_q : next_pc;

  // state updates
  assign pc_d     = commit ? next_pc : pc_q;
  assign idx_d    = commit ? idx_nx : idx_q;
  assign dly_d    = commit ? dly_nx : dly_q;
  assign sp_d     = commit ? sp_nx : sp_q;
  assign halted_d = halted_q || (ex_fire && fault);

  assign ram_we = commit && wr && (x != VF_REG);
  assign vf_we  = commit && ((wr && (x == VF_REG)) || shr);
  assign vf_wd  = shr ? {{(DAT_W-1){1'b0}}, vx[0]} : wval;
  assign vf_d   = vf_we ? vf_wd : vf_q;

  always_comb begin
    vld_d = vld_q;
    if (ram_we) begin
      vld_d[x] = 1'b1;
    end
  end

  // read addresses for the beat being accepted
  assign rx_addr  = s_axis_tdata[11:8];
  assign ry_addr  = s_axis_tdata[7:4];
  assign vx_hit   = ram_we && (x == rx_addr);
  assign vy_hit   = ram_we && (x == ry_addr);
  assign sp_rd    = sp_d - SP_W'(1);
  assign st_raddr = sp_rd[SADDR_W-1:0];
  assign st_hit   = commit && push && (sp_q[SADDR_W-1:0] == st_raddr);

  c8ie_ram #(.WIDTH(DAT_W), .DEPTH(NUM_VREGS)) u_vx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (x),
    .wdata_i (wval),
    .re_i    (s_fire),
    .raddr_i (rx_addr),
    .rdata_o (vx_rd)
  );

  c8ie_ram #(.WIDTH(DAT_W), .DEPTH(NUM_VREGS)) u_vy_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (x),
    .wdata_i (wval),
    .re_i    (s_fire),
    .raddr_i (ry_addr),
    .rdata_o (vy_rd)
  );

  c8ie_ram #(.WIDTH(PC_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (commit && push),
    .waddr_i (sp_q[SADDR_W-1:0]),
    .wdata_i (pc_q),
    .re_i    (s_fire),
    .raddr_i (st_raddr),
    .rdata_o (st_rd)
  );

  // result beat
  always_comb begin
    out_data_d = '0;
    out_data_d[PC_W-1:0] = pc_out;
    out_data_d[PC_W +: IDX_W] = idx_d;
    out_data_d[PC_W+IDX_W] = commit && wr;
    out_data_d[PC_W+IDX_W+1 +: VREG_W] = (commit && wr) ? x : '0;
    out_data_d[PC_W+IDX_W+1+VREG_W +: DAT_W] = (commit && wr) ? wval : '0;
    out_data_d[PC_W+IDX_W+1+VREG_W+DAT_W +: 2] = st_out;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (ex_fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q      <= PC_RESET;
      idx_q     <= '0;
      sp_q      <= '0;
      dly_q     <= '0;
      vf_q      <= '0;
      vld_q     <= '0;
      halted_q  <= 1'b0;
      vx_hit_q  <= 1'b0;
      vy_hit_q  <= 1'b0;
      vx_live_q <= 1'b0;
      vy_live_q <= 1'b0;
      st_hit_q  <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      pc_q      <= pc_d;
      idx_q     <= idx_d;
      sp_q      <= sp_d;
      dly_q     <= dly_d;
      vf_q      <= vf_d;
      vld_q     <= vld_d;
      halted_q  <= halted_d;
      if (s_fire) begin
        vx_hit_q  <= vx_hit;
        vy_hit_q  <= vy_hit;
        vx_live_q <= vx_hit || vld_q[rx_addr];
        vy_live_q <= vy_hit || vld_q[ry_addr];
        st_hit_q  <= st_hit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ins_q    <= s_axis_tdata;
      vx_fwd_q <= wval;
      vy_fwd_q <= wval;
      st_fwd_q <= pc_q;
    end
    if (ex_fire) begin
      out_data_q <= out_data_d;
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt state cleared without reset");

  a_halt_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && halted_q) |=>
      (out_data_q[PC_W+IDX_W+1+VREG_W+DAT_W +: 2] == ST_HALT) &&
      !out_data_q[PC_W+IDX_W])
    else $error("halted core produced a non-halt result");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire |=> (sp_q <= SP_W'(STACK_DEPTH)))
    else $error("stack pointer beyond stack depth");

  a_frozen_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && fault) |=> $stable(pc_q) && $stable(sp_q))
    else $error("faulting instruction changed pc or stack pointer");

endmodule

/* rtl/c8ie_ram.sv */
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module c8ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
